// ----- sv/edu_pkg.sv -----
// shared types and constants for the euclidean distance unit
`default_nettype none
package edu_pkg;

    localparam int QIDX_W      = 10;
    localparam int RIDX_W      = 12;
    localparam int ELEM_W      = 16;
    localparam int DIFF_W      = ELEM_W + 1;
    localparam int SQ_W        = 32;
    localparam int ACC_W       = 42;
    localparam int DIST_W      = 21;
    localparam int LEN_W       = 11;
    localparam int CNT_W       = 11;
    localparam int DIM_MAX     = 1024;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - QIDX_W - RIDX_W - DIST_W;

    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = 2;
    localparam int Q_CW        = 3;

    localparam int SQRT_STEPS  = DIST_W;
    localparam int STEP_W      = 5;
    localparam int REM_W       = DIST_W + 1;

    typedef struct packed {
        logic [QIDX_W-1:0] query_index;
        logic [RIDX_W-1:0] ref_index;
        logic [ACC_W-1:0]  sum;
    } dist_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CALC,
        BK_HOLD
    } back_state_t;

endpackage
`default_nettype wire

// ----- sv/edu_front.sv -----
// front part: takes element pairs, squares differences, accumulates per vector
`default_nettype none
module edu_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // query_index, ref_index, q_element, x_element, zero pad
    input  wire logic [edu_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic [edu_pkg::LEN_W-1:0]     cfg_wr_data,
    output logic                               push,
    output edu_pkg::dist_job_t                 push_job,
    input  wire edu_pkg::queue_status_t        q_status
);
    import edu_pkg::*;

    logic [LEN_W-1:0]         len_reg;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [LEN_W-1:0]         eff_len;
    logic [CNT_W-1:0]         cnt_plus;
    logic                     accept, adv, stall;

    logic [QIDX_W-1:0]        in_qidx;
    logic [RIDX_W-1:0]        in_ridx;
    logic [ELEM_W-1:0]        in_q, in_x;
    logic signed [DIFF_W-1:0] in_diff;
    logic                     a_last_next;

    logic                     a_valid_reg, a_last_reg;
    logic signed [DIFF_W-1:0] a_diff_reg;
    logic [QIDX_W-1:0]        a_qidx_reg;
    logic [RIDX_W-1:0]        a_ridx_reg;

    logic signed [2*DIFF_W-1:0] prod;
    logic                     b_valid_reg, b_last_reg;
    logic [SQ_W-1:0]          b_sq_reg;
    logic [QIDX_W-1:0]        b_qidx_reg;
    logic [RIDX_W-1:0]        b_ridx_reg;

    logic [ACC_W-1:0]         acc_reg, acc_next, acc_sum;

    assign in_qidx = s_axis_tdata[QIDX_W-1:0];
    assign in_ridx = s_axis_tdata[QIDX_W+RIDX_W-1:QIDX_W];
    assign in_q    = s_axis_tdata[QIDX_W+RIDX_W+ELEM_W-1:QIDX_W+RIDX_W];
    assign in_x    = s_axis_tdata[QIDX_W+RIDX_W+2*ELEM_W-1:QIDX_W+RIDX_W+ELEM_W];
    assign in_diff = $signed({in_q[ELEM_W-1], in_q}) - $signed({in_x[ELEM_W-1], in_x});

    // zero length acts as one, anything above the max saturates
    always_comb
    begin
        priority if (len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(DIM_MAX))
        begin
            eff_len = LEN_W'(DIM_MAX);
        end
        else
        begin
            eff_len = len_reg;
        end
    end

    assign cnt_plus    = cnt_reg + CNT_W'(1);
    assign a_last_next = (cnt_plus >= eff_len);

    // whole pipe holds while a finished vector cannot enter the queue
    assign stall         = b_valid_reg & b_last_reg & q_status.full;
    assign adv           = ~stall;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid & adv;

    assign cnt_next = a_last_next ? '0 : cnt_plus;

    assign prod    = a_diff_reg * a_diff_reg;
    assign acc_sum = acc_reg + ACC_W'(b_sq_reg);

    assign push              = adv & b_valid_reg & b_last_reg;
    assign push_job.query_index = b_qidx_reg;
    assign push_job.ref_index   = b_ridx_reg;
    assign push_job.sum         = acc_sum;

    always_comb
    begin
        acc_next = acc_reg;
        if (adv && b_valid_reg)
        begin
            acc_next = b_last_reg ? '0 : acc_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= LEN_W'(1);
            cnt_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                len_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                cnt_reg <= cnt_next;
            end
            if (adv)
            begin
                a_valid_reg <= accept;
                b_valid_reg <= a_valid_reg;
            end
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_diff_reg <= in_diff;
            a_qidx_reg <= in_qidx;
            a_ridx_reg <= in_ridx;
            a_last_reg <= a_last_next;
        end
        if (adv && a_valid_reg)
        begin
            b_sq_reg   <= prod[SQ_W-1:0];
            b_qidx_reg <= a_qidx_reg;
            b_ridx_reg <= a_ridx_reg;
            b_last_reg <= a_last_reg;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(DIM_MAX))
        else $error("element count out of range");

    a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && a_last_next) |=> (cnt_reg == '0))
        else $error("element count not cleared at vector end");
`endif

endmodule
`default_nettype wire

// ----- sv/edu_queue.sv -----
// short queue of finished sums between front and back parts
`default_nettype none
module edu_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire edu_pkg::dist_job_t push_job,
    input  wire logic              pop,
    output edu_pkg::dist_job_t     head,
    output edu_pkg::queue_status_t status
);
    import edu_pkg::*;

    dist_job_t         entry_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0]   count_reg, count_next;

    assign status.full  = (count_reg == Q_CW'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + Q_CW'(1);
            2'b01:   count_next = count_reg - Q_CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// ----- sv/edu_back.sv -----
// back part: bit-serial integer square root and output register
`default_nettype none
module edu_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire edu_pkg::dist_job_t             head,
    input  wire edu_pkg::queue_status_t         q_status,
    output logic                                pop,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // out_query_index, out_ref_index, distance, zero pad
    output logic [edu_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import edu_pkg::*;

    back_state_t        state_reg, state_next;
    logic [QIDX_W-1:0]  qidx_reg, qidx_next;
    logic [RIDX_W-1:0]  ridx_reg, ridx_next;
    logic [ACC_W-1:0]   rad_reg, rad_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [DIST_W-1:0]  root_reg, root_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    logic               out_valid_reg, out_valid_next;
    logic [QIDX_W-1:0]  out_qidx_reg, out_qidx_next;
    logic [RIDX_W-1:0]  out_ridx_reg, out_ridx_next;
    logic [DIST_W-1:0]  out_dist_reg, out_dist_next;

    logic [REM_W+1:0]   rem_sh, trial, rem_sub;
    logic               take;

    // one root bit per cycle: bring down two radicand bits, try subtracting 4*root+1
    assign rem_sh  = {rem_reg, rad_reg[ACC_W-1:ACC_W-2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign rem_sub = rem_sh - trial;
    assign take    = (rem_sh >= trial);

    always_comb
    begin
        state_next     = state_reg;
        qidx_next      = qidx_reg;
        ridx_next      = ridx_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_qidx_next  = out_qidx_reg;
        out_ridx_next  = out_ridx_reg;
        out_dist_next  = out_dist_reg;
        pop            = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    qidx_next  = head.query_index;
                    ridx_next  = head.ref_index;
                    rad_next   = head.sum;
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = BK_CALC;
                end
            end
            BK_CALC:
            begin
                rad_next  = {rad_reg[ACC_W-3:0], 2'b00};
                rem_next  = take ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
                root_next = {root_reg[DIST_W-2:0], take};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = BK_HOLD;
                end
            end
            BK_HOLD:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_qidx_next  = qidx_reg;
                    out_ridx_next  = ridx_reg;
                    out_dist_next  = root_reg;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qidx_reg     <= qidx_next;
        ridx_reg     <= ridx_next;
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        out_qidx_reg <= out_qidx_next;
        out_ridx_reg <= out_ridx_next;
        out_dist_reg <= out_dist_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_dist_reg, out_ridx_reg, out_qidx_reg};

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_CALC) |-> (step_reg < STEP_W'(SQRT_STEPS)))
        else $error("square root step counter out of range");
`endif

endmodule
`default_nettype wire

// ----- sv/euclidean_distance_unit.sv -----
// top level of the euclidean distance unit
// path of a finished vector: front registers a and b, queue, back states idle,
// calc and hold, output register; throughput: one element beat per cycle in
// a vector unless a finished vector waits on a full queue, a 4-entry queue
// absorbs bursts; the root unit holds one sum at a time, popping only when idle
// reset: rst_n clears counters, accumulator, queue and output valid; length = 1
`default_nettype none
module euclidean_distance_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // query_index, ref_index, q_element, x_element, zero pad
    input  wire logic [edu_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // out_query_index, out_ref_index, distance, zero pad
    output logic [edu_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  wire logic                           cfg_wr_en,
    input  wire logic [edu_pkg::LEN_W-1:0]      cfg_wr_data
);
    import edu_pkg::*;

    logic          push, pop;
    dist_job_t     push_job, head;
    queue_status_t q_status;

    edu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .push          (push),
        .push_job      (push_job),
        .q_status      (q_status)
    );

    edu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    edu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
`default_nettype wire
